### rtl/core/atl_pkg.sv
// Shared constants, the tangent table and the lane status type of the tilt-angle block.
`default_nettype none

package atl_pkg;

  localparam int TableEntries  = 90;
  localparam int AngleFracBits = 8;
  localparam int TanPoints     = 90;
  localparam int TanIdxW       = 7;
  localparam int OverDeg       = 100;
  localparam int TanScale      = 10000;

  // Tangent of each whole degree from 0 to 89, scaled by 10000.
  function automatic logic [19:0] tan_e4(input logic [TanIdxW-1:0] idx);
    logic [19:0] t;
    case (idx)
      7'd0: t = 20'd0;        7'd1: t = 20'd175;      7'd2: t = 20'd349;
      7'd3: t = 20'd524;      7'd4: t = 20'd699;      7'd5: t = 20'd875;
      7'd6: t = 20'd1051;     7'd7: t = 20'd1228;     7'd8: t = 20'd1405;
      7'd9: t = 20'd1584;     7'd10: t = 20'd1763;    7'd11: t = 20'd1944;
      7'd12: t = 20'd2126;    7'd13: t = 20'd2309;    7'd14: t = 20'd2493;
      7'd15: t = 20'd2679;    7'd16: t = 20'd2867;    7'd17: t = 20'd3057;
      7'd18: t = 20'd3249;    7'd19: t = 20'd3443;    7'd20: t = 20'd3640;
      7'd21: t = 20'd3839;    7'd22: t = 20'd4040;    7'd23: t = 20'd4245;
      7'd24: t = 20'd4452;    7'd25: t = 20'd4663;    7'd26: t = 20'd4877;
      7'd27: t = 20'd5095;    7'd28: t = 20'd5317;    7'd29: t = 20'd5543;
      7'd30: t = 20'd5774;    7'd31: t = 20'd6009;    7'd32: t = 20'd6249;
      7'd33: t = 20'd6494;    7'd34: t = 20'd6745;    7'd35: t = 20'd7002;
      7'd36: t = 20'd7265;    7'd37: t = 20'd7536;    7'd38: t = 20'd7813;
      7'd39: t = 20'd8098;    7'd40: t = 20'd8391;    7'd41: t = 20'd8693;
      7'd42: t = 20'd9004;    7'd43: t = 20'd9325;    7'd44: t = 20'd9657;
      7'd45: t = 20'd10000;   7'd46: t = 20'd10355;   7'd47: t = 20'd10724;
      7'd48: t = 20'd11106;   7'd49: t = 20'd11504;   7'd50: t = 20'd11918;
      7'd51: t = 20'd12349;   7'd52: t = 20'd12799;   7'd53: t = 20'd13270;
      7'd54: t = 20'd13764;   7'd55: t = 20'd14281;   7'd56: t = 20'd14826;
      7'd57: t = 20'd15399;   7'd58: t = 20'd16003;   7'd59: t = 20'd16643;
      7'd60: t = 20'd17321;   7'd61: t = 20'd18040;   7'd62: t = 20'd18807;
      7'd63: t = 20'd19626;   7'd64: t = 20'd20503;   7'd65: t = 20'd21445;
      7'd66: t = 20'd22460;   7'd67: t = 20'd23559;   7'd68: t = 20'd24751;
      7'd69: t = 20'd26051;   7'd70: t = 20'd27475;   7'd71: t = 20'd29042;
      7'd72: t = 20'd30777;   7'd73: t = 20'd32709;   7'd74: t = 20'd34874;
      7'd75: t = 20'd37321;   7'd76: t = 20'd40108;   7'd77: t = 20'd43315;
      7'd78: t = 20'd47046;   7'd79: t = 20'd51446;   7'd80: t = 20'd56713;
      7'd81: t = 20'd63138;   7'd82: t = 20'd71154;   7'd83: t = 20'd81443;
      7'd84: t = 20'd95144;   7'd85: t = 20'd114301;  7'd86: t = 20'd143007;
      7'd87: t = 20'd190811;  7'd88: t = 20'd286363;  7'd89: t = 20'd572900;
      default: t = 20'd0;
    endcase
    return t;
  endfunction

  // What one lane reports to the merging stage.
  typedef struct packed {
    logic               idle;
    logic               done;
    logic signed [15:0] angle;
    logic               over;
  } lane_stat_t;

endpackage

`default_nettype wire

### rtl/core/atl_lane.sv
// One arctangent lane: sum of squares, square root, division and table interpolation.
`default_nettype none

module atl_lane #(
  parameter int TABLE_ENTRIES       = atl_pkg::TableEntries,
  parameter int ANGLE_FRACTION_BITS = atl_pkg::AngleFracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               take_i,
  input  wire logic               mode_z_i,
  input  wire logic signed [15:0] sq_a_i,
  input  wire logic signed [15:0] sq_b_i,
  input  wire logic signed [15:0] num_i,
  output atl_pkg::lane_stat_t     stat_o
);

  localparam int Afb  = ANGLE_FRACTION_BITS;
  localparam int Lim  = (TABLE_ENTRIES > atl_pkg::TanPoints) ? atl_pkg::TanPoints :
                        ((TABLE_ENTRIES < 2) ? 2 : TABLE_ENTRIES);
  localparam int MagW = 7 + Afb;
  localparam int IdxW = atl_pkg::TanIdxW;
  localparam logic [27:0] TopTan =
    {atl_pkg::tan_e4(IdxW'(Lim - 1)), 8'd0};
  localparam logic [MagW-1:0] Marker = MagW'(atl_pkg::OverDeg << Afb);

  localparam logic [3:0] StIdle = 4'd0;
  localparam logic [3:0] StSq   = 4'd1;
  localparam logic [3:0] StRoot = 4'd2;
  localparam logic [3:0] StMul  = 4'd3;
  localparam logic [3:0] StDiv  = 4'd4;
  localparam logic [3:0] StChk  = 4'd5;
  localparam logic [3:0] StSrch = 4'd6;
  localparam logic [3:0] StFrac = 4'd7;
  localparam logic [3:0] StFin  = 4'd8;
  localparam logic [3:0] StDone = 4'd9;

  logic [3:0]         state_q, state_d;
  logic [15:0]        am_q, am_d, bm_q, bm_d, nm_q, nm_d;
  logic               neg_q, neg_d;
  logic [31:0]        sum_q, sum_d;
  logic [47:0]        op_q, op_d, res_q, res_d, one_q, one_d;
  logic [5:0]         cnt_q, cnt_d;
  logic [47:0]        dv_q, dv_d;
  logic [23:0]        dr_q, dr_d;
  logic [23:0]        rem_q, rem_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [27:0]        frem_q, frem_d, fden_q, fden_d;
  logic [Afb-1:0]     fq_q, fq_d;
  logic [MagW-1:0]    mag_q, mag_d;
  logic               over_q, over_d;
  logic signed [15:0] angle_q, angle_d;

  logic [31:0] sq_a, sq_b;
  logic [48:0] trial;
  logic [37:0] root_prod;
  logic [29:0] num_prod;
  logic [23:0] den;
  logic [47:0] dividend;
  logic        num_zero;
  logic [24:0] rem2;
  logic [27:0] hi, lo;
  logic [28:0] frem2;
  logic        fbit;
  logic [23:0] mag_ext;

  assign sq_a      = am_q * am_q;
  assign sq_b      = bm_q * bm_q;
  assign trial     = {1'b0, res_q} + {1'b0, one_q};
  assign root_prod = 38'(res_q[23:0]) * 38'(atl_pkg::TanScale);
  assign num_prod  = 30'(nm_q) * 30'(atl_pkg::TanScale);
  assign rem2      = {rem_q, dv_q[47]};
  assign hi        = {atl_pkg::tan_e4(idx_q), 8'd0};
  assign lo        = {atl_pkg::tan_e4(idx_q - IdxW'(1)), 8'd0};
  assign frem2     = {frem_q, 1'b0};
  assign fbit      = (frem2 >= {1'b0, fden_q});
  assign mag_ext   = 24'(mag_q);

  // Ratio operands: the side lanes divide by the root, the z lane by |z|.
  always_comb begin
    if (mode_z_i) begin
      den      = 24'(nm_q);
      dividend = 48'(root_prod);
      num_zero = (res_q[23:0] == 24'd0);
    end else begin
      den      = res_q[23:0];
      dividend = {2'b00, num_prod, 16'd0};
      num_zero = (nm_q == 16'd0);
    end
  end

  // Sequencer for one item.
  always_comb begin
    state_d = state_q;
    am_d = am_q; bm_d = bm_q; nm_d = nm_q; neg_d = neg_q;
    sum_d = sum_q; op_d = op_q; res_d = res_q; one_d = one_q;
    cnt_d = cnt_q; dv_d = dv_q; dr_d = dr_q; rem_d = rem_q;
    idx_d = idx_q; frem_d = frem_q; fden_d = fden_q; fq_d = fq_q;
    mag_d = mag_q; over_d = over_q; angle_d = angle_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          am_d    = sq_a_i[15] ? 16'(-sq_a_i) : 16'(sq_a_i);
          bm_d    = sq_b_i[15] ? 16'(-sq_b_i) : 16'(sq_b_i);
          nm_d    = num_i[15] ? 16'(-num_i) : 16'(num_i);
          neg_d   = num_i[15];
          state_d = StSq;
        end
      end
      StSq: begin
        sum_d   = sq_a + sq_b;
        state_d = StRoot;
        op_d    = 48'd0;
        res_d   = 48'd0;
        one_d   = 48'd1 << 46;
        cnt_d   = 6'd24;
      end
      StRoot: begin
        // The first step loads the scaled sum; later steps find one root bit each.
        if (cnt_q == 6'd24 && one_q == (48'd1 << 46) && res_q == 48'd0 &&
            op_q == 48'd0 && sum_q != 32'd0) begin
          op_d = {sum_q, 16'd0};
        end else begin
          if ({1'b0, op_q} >= trial) begin
            op_d  = op_q - trial[47:0];
            res_d = (res_q >> 1) + one_q;
          end else begin
            res_d = res_q >> 1;
          end
          one_d = one_q >> 2;
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) begin
            state_d = StMul;
          end
        end
      end
      StMul: begin
        if (den == 24'd0) begin
          over_d  = 1'b1;
          mag_d   = num_zero ? '0 : Marker;
          state_d = StFin;
        end else begin
          dv_d    = dividend;
          dr_d    = den;
          rem_d   = 24'd0;
          cnt_d   = 6'd48;
          state_d = StDiv;
        end
      end
      StDiv: begin
        // Restoring division, one quotient bit a cycle.
        if (rem2 >= {1'b0, dr_q}) begin
          rem_d = 24'(rem2 - {1'b0, dr_q});
          dv_d  = {dv_q[46:0], 1'b1};
        end else begin
          rem_d = rem2[23:0];
          dv_d  = {dv_q[46:0], 1'b0};
        end
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          state_d = StChk;
        end
      end
      StChk: begin
        if (dv_q > 48'(TopTan)) begin
          over_d  = 1'b1;
          mag_d   = Marker;
          state_d = StFin;
        end else begin
          over_d  = 1'b0;
          idx_d   = '0;
          state_d = StSrch;
        end
      end
      StSrch: begin
        // Walk the table to the first entry not below the tangent.
        if (dv_q == 48'(hi)) begin
          mag_d   = MagW'({idx_q, Afb'(0)});
          state_d = StFin;
        end else if (dv_q < 48'(hi)) begin
          frem_d  = dv_q[27:0] - lo;
          fden_d  = hi - lo;
          fq_d    = '0;
          idx_d   = idx_q - IdxW'(1);
          cnt_d   = 6'(Afb);
          state_d = StFrac;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      StFrac: begin
        // Fraction inside the segment, one bit a cycle.
        frem_d = fbit ? 28'(frem2 - {1'b0, fden_q}) : frem2[27:0];
        fq_d   = {fq_q[Afb-2:0], fbit};
        cnt_d  = cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          mag_d   = MagW'({idx_q, fq_d});
          state_d = StFin;
        end
      end
      StFin: begin
        if (neg_q) begin
          angle_d = (mag_ext > 24'd32768) ? -16'sd32768 : 16'(-mag_ext);
        end else begin
          angle_d = (mag_ext > 24'd32767) ? 16'sd32767 : 16'(mag_ext);
        end
        state_d = StDone;
      end
      StDone: begin
        if (take_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    am_q <= am_d; bm_q <= bm_d; nm_q <= nm_d; neg_q <= neg_d;
    sum_q <= sum_d; op_q <= op_d; res_q <= res_d; one_q <= one_d;
    cnt_q <= cnt_d; dv_q <= dv_d; dr_q <= dr_d; rem_q <= rem_d;
    idx_q <= idx_d; frem_q <= frem_d; fden_q <= fden_d; fq_q <= fq_d;
    mag_q <= mag_d; over_q <= over_d; angle_q <= angle_d;
  end

  assign stat_o.idle  = (state_q == StIdle);
  assign stat_o.done  = (state_q == StDone);
  assign stat_o.angle = angle_q;
  assign stat_o.over  = over_q;

endmodule

`default_nettype wire

### rtl/core/atl_merge.sv
// Merging stage: gathers the three lane results into the output register.
`default_nettype none

module atl_merge (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire atl_pkg::lane_stat_t  stat_x_i,
  input  wire atl_pkg::lane_stat_t  stat_y_i,
  input  wire atl_pkg::lane_stat_t  stat_z_i,
  output logic                      take_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [15:0]        angle_x_o,
  output logic signed [15:0]        angle_y_o,
  output logic signed [15:0]        angle_z_o,
  output logic                      over_x_o,
  output logic                      over_y_o,
  output logic                      over_z_o
);

  logic        valid_q, valid_d;
  logic signed [15:0] ax_q, ay_q, az_q;
  logic        ox_q, oy_q, oz_q;
  logic        load;

  // Load once every lane is finished and the output register is free.
  assign load    = stat_x_i.done && stat_y_i.done && stat_z_i.done &&
                   (!valid_q || out_ready_i);
  assign valid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Result item payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      ax_q <= stat_x_i.angle;
      ay_q <= stat_y_i.angle;
      az_q <= stat_z_i.angle;
      ox_q <= stat_x_i.over;
      oy_q <= stat_y_i.over;
      oz_q <= stat_z_i.over;
    end
  end

  assign take_o      = load;
  assign out_valid_o = valid_q;
  assign angle_x_o   = ax_q;
  assign angle_y_o   = ay_q;
  assign angle_z_o   = az_q;
  assign over_x_o    = ox_q;
  assign over_y_o    = oy_q;
  assign over_z_o    = oz_q;

endmodule

`default_nettype wire

### rtl/core/accel_tilt_angles.sv
// Top level of the accelerometer tilt-angle block.
// Each item is one (x, y, z) sample and gives one result item with three
// arctangent angles in units of 1/2^ANGLE_FRACTION_BITS degree and three
// over-range flags. Three lanes of one design work on the x, y and z ratios at
// the same time; each lane forms a root of a sum of squares, a 48-bit
// restoring division, a walk along the one-degree tangent table and a
// fraction division. A ratio with a zero denominator skips the division, the
// walk and the fraction division, and an over-range ratio skips the walk and
// the fraction division; the result item waits for the slowest lane. A new item
// is taken once all lanes are free, even while the previous result still
// waits at the output.
`default_nettype none

module accel_tilt_angles #(
  parameter int TABLE_ENTRIES       = atl_pkg::TableEntries,
  parameter int ANGLE_FRACTION_BITS = atl_pkg::AngleFracBits
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      angle_x_o,
  output logic signed [15:0]      angle_y_o,
  output logic signed [15:0]      angle_z_o,
  output logic                    over_x_o,
  output logic                    over_y_o,
  output logic                    over_z_o
);

  atl_pkg::lane_stat_t stat_x, stat_y, stat_z;
  logic start;
  logic take;

  // An item enters when every lane is idle.
  assign in_ready_o = stat_x.idle && stat_y.idle && stat_z.idle;
  assign start      = in_valid_i && in_ready_o;

  atl_lane #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_lane_x (
    .clk_i, .rst_ni, .start_i(start), .take_i(take), .mode_z_i(1'b0),
    .sq_a_i(accel_y_i), .sq_b_i(accel_z_i), .num_i(accel_x_i), .stat_o(stat_x)
  );

  atl_lane #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_lane_y (
    .clk_i, .rst_ni, .start_i(start), .take_i(take), .mode_z_i(1'b0),
    .sq_a_i(accel_x_i), .sq_b_i(accel_z_i), .num_i(accel_y_i), .stat_o(stat_y)
  );

  atl_lane #(
    .TABLE_ENTRIES(TABLE_ENTRIES), .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
  ) u_lane_z (
    .clk_i, .rst_ni, .start_i(start), .take_i(take), .mode_z_i(1'b1),
    .sq_a_i(accel_x_i), .sq_b_i(accel_y_i), .num_i(accel_z_i), .stat_o(stat_z)
  );

  atl_merge u_merge (
    .clk_i, .rst_ni,
    .stat_x_i(stat_x), .stat_y_i(stat_y), .stat_z_i(stat_z),
    .take_o(take), .out_valid_o, .out_ready_i,
    .angle_x_o, .angle_y_o, .angle_z_o, .over_x_o, .over_y_o, .over_z_o
  );

endmodule

`default_nettype wire

### rtl/core/atl_checker.sv
// Port-level checks for the tilt-angle block and their binding.
`default_nettype none

module atl_checker #(
  parameter int ANGLE_FRACTION_BITS = atl_pkg::AngleFracBits
) (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [15:0] angle_x_o,
  input wire logic signed [15:0] angle_z_o,
  input wire logic               over_x_o,
  input wire logic               over_z_o
);

  localparam int RawBound = 89 << ANGLE_FRACTION_BITS;
  localparam int Bound    = (RawBound > 32767) ? 32767 : RawBound;

  // A result held back stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A held result keeps its x angle.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(angle_x_o))
    else $error("result item changed while stalled");

  // Taking an item makes the lanes busy, so the input is not taken twice in a row.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken twice in a row");

  // Without either flag the x and z angles lie inside the table range.
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !over_x_o && !over_z_o |->
      (int'(angle_x_o) <= Bound) && (int'(angle_x_o) >= -Bound) &&
      (int'(angle_z_o) <= Bound) && (int'(angle_z_o) >= -Bound))
    else $error("unflagged angle outside table range");

endmodule

bind accel_tilt_angles atl_checker #(
  .ANGLE_FRACTION_BITS(ANGLE_FRACTION_BITS)
) u_atl_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
  .angle_x_o, .angle_z_o, .over_x_o, .over_z_o
);

`default_nettype wire
